[hdl/cbct_pkg.sv]
// ----------------------------------------------------------------------------
// cbct_pkg: shared constants for the circle and box collision test
// Default fixed-point formats and the shape selector code.
// ----------------------------------------------------------------------------
package cbct_pkg;

	localparam int DEF_FRAC_BITS      = 16;
	localparam int DEF_COMPONENT_BITS = 32;

	// Shape selector: bit0 first body is a circle, bit1 second body is a circle.
	localparam logic [1:0] SHAPE_CIRCLE_PAIR = 2'b11;

endpackage

[hdl/cbct_unpack.sv]
// ----------------------------------------------------------------------------
// cbct_unpack: first pipeline stage
// Split packed vectors, clamp components to the symmetric range, form the
// offset, relative velocity and extent sums.
// ----------------------------------------------------------------------------
module cbct_unpack #(
	parameter int COMPONENT_BITS = cbct_pkg::DEF_COMPONENT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       shape_pair,
	input  logic [63:0]                      first_position,
	input  logic [63:0]                      second_position,
	input  logic [63:0]                      first_velocity,
	input  logic [63:0]                      second_velocity,
	input  logic [63:0]                      first_extent,
	input  logic [63:0]                      second_extent,
	input  logic [63:0]                      second_normal,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             circle,
	output logic signed [COMPONENT_BITS-1:0] dx,
	output logic signed [COMPONENT_BITS-1:0] dy,
	output logic signed [COMPONENT_BITS-1:0] rvx,
	output logic signed [COMPONENT_BITS-1:0] rvy,
	output logic signed [COMPONENT_BITS-1:0] vx,
	output logic signed [COMPONENT_BITS-1:0] vy,
	output logic signed [COMPONENT_BITS-1:0] ax,
	output logic signed [COMPONENT_BITS-1:0] ay,
	output logic [COMPONENT_BITS:0]          reach1,
	output logic [COMPONENT_BITS:0]          reach2,
	output logic [COMPONENT_BITS-1:0]        side1,
	output logic [COMPONENT_BITS-1:0]        side2
);
	import cbct_pkg::*;

	localparam int C = COMPONENT_BITS;
	localparam logic signed [C-1:0] POS_MAX = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] NEG_MAX = {1'b1, {(C-2){1'b0}}, 1'b1};
	localparam logic signed [C:0]   WIDE_POS = {2'b00, {(C-1){1'b1}}};
	localparam logic signed [C:0]   WIDE_NEG = {2'b11, {(C-2){1'b0}}, 1'b1};

	// most negative code reads as the most negative symmetric value
	function automatic logic signed [C-1:0] sym(input logic [C-1:0] raw);
		logic signed [C-1:0] v;
		v = signed'(raw);
		if (raw == {1'b1, {(C-1){1'b0}}})
			v = NEG_MAX;
		return v;
	endfunction

	function automatic logic signed [C-1:0] sat_diff(input logic signed [C-1:0] a,
		input logic signed [C-1:0] b);
		logic signed [C:0] ae;
		logic signed [C:0] be;
		logic signed [C:0] d;
		logic signed [C-1:0] r;
		ae = (C+1)'(a);
		be = (C+1)'(b);
		d  = ae - be;
		if (d > WIDE_POS)
			r = POS_MAX;
		else if (d < WIDE_NEG)
			r = NEG_MAX;
		else
			r = signed'(d[C-1:0]);
		return r;
	endfunction

	logic                circle_s1;
	logic                valid_s1;
	logic signed [C-1:0] dx_s1, dy_s1, rvx_s1, rvy_s1, vx_s1, vy_s1, ax_s1, ay_s1;
	logic [C:0]          reach1_s1, reach2_s1;
	logic [C-1:0]        side1_s1, side2_s1;

	logic signed [C-1:0] v1x, v1y;
	assign v1x = sym(first_velocity[C-1:0]);
	assign v1y = sym(first_velocity[2*C-1:C]);

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			circle_s1 <= (shape_pair == SHAPE_CIRCLE_PAIR);
			dx_s1     <= sat_diff(sym(second_position[C-1:0]), sym(first_position[C-1:0]));
			dy_s1     <= sat_diff(sym(second_position[2*C-1:C]),
				sym(first_position[2*C-1:C]));
			rvx_s1    <= sat_diff(v1x, sym(second_velocity[C-1:0]));
			rvy_s1    <= sat_diff(v1y, sym(second_velocity[2*C-1:C]));
			vx_s1     <= v1x;
			vy_s1     <= v1y;
			ax_s1     <= sym(second_normal[C-1:0]);
			ay_s1     <= sym(second_normal[2*C-1:C]);
			reach1_s1 <= {1'b0, first_extent[C-1:0]} + {1'b0, second_extent[C-1:0]};
			reach2_s1 <= {1'b0, first_extent[2*C-1:C]} + {1'b0, second_extent[2*C-1:C]};
			side1_s1  <= second_extent[2*C-1:C];
			side2_s1  <= second_extent[C-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign circle    = circle_s1;
	assign dx        = dx_s1;
	assign dy        = dy_s1;
	assign rvx       = rvx_s1;
	assign rvy       = rvy_s1;
	assign vx        = vx_s1;
	assign vy        = vy_s1;
	assign ax        = ax_s1;
	assign ay        = ay_s1;
	assign reach1    = reach1_s1;
	assign reach2    = reach2_s1;
	assign side1     = side1_s1;
	assign side2     = side2_s1;

endmodule

[hdl/cbct_mult.sv]
// ----------------------------------------------------------------------------
// cbct_mult: second pipeline stage
// Shared multiplier bank; operands steered by the circle-pair flag.
// ----------------------------------------------------------------------------
module cbct_mult #(
	parameter int COMPONENT_BITS = cbct_pkg::DEF_COMPONENT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               circle,
	input  logic signed [COMPONENT_BITS-1:0]   dx,
	input  logic signed [COMPONENT_BITS-1:0]   dy,
	input  logic signed [COMPONENT_BITS-1:0]   rvx,
	input  logic signed [COMPONENT_BITS-1:0]   rvy,
	input  logic signed [COMPONENT_BITS-1:0]   vx,
	input  logic signed [COMPONENT_BITS-1:0]   vy,
	input  logic signed [COMPONENT_BITS-1:0]   ax,
	input  logic signed [COMPONENT_BITS-1:0]   ay,
	input  logic [COMPONENT_BITS:0]            reach1,
	input  logic [COMPONENT_BITS:0]            reach2,
	input  logic [COMPONENT_BITS-1:0]          side1,
	input  logic [COMPONENT_BITS-1:0]          side2,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               circle_o,
	output logic signed [2*COMPONENT_BITS-1:0] prod [8],
	output logic [2*COMPONENT_BITS+1:0]        rs_sq,
	output logic signed [COMPONENT_BITS-1:0]   ax_o,
	output logic signed [COMPONENT_BITS-1:0]   ay_o,
	output logic [COMPONENT_BITS:0]            reach1_o,
	output logic [COMPONENT_BITS:0]            reach2_o,
	output logic [COMPONENT_BITS-1:0]          side1_o,
	output logic [COMPONENT_BITS-1:0]          side2_o
);
	import cbct_pkg::*;

	localparam int C = COMPONENT_BITS;

	logic                  valid_s2;
	logic                  circle_s2;
	logic signed [2*C-1:0] prod_s2 [8];
	logic [2*C+1:0]        rs_sq_s2;
	logic signed [C-1:0]   ax_s2, ay_s2;
	logic [C:0]            reach1_s2, reach2_s2;
	logic [C-1:0]          side1_s2, side2_s2;

	// circle pair: dx*dx, dy*dy, dx*rvx, dy*rvy; box: dx*ax, dy*ay, dx*ay, dy*ax
	logic signed [C-1:0] op0, op1, op2, op3;
	assign op0 = circle ? dx  : ax;
	assign op1 = circle ? dy  : ay;
	assign op2 = circle ? rvx : ay;
	assign op3 = circle ? rvy : ax;

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			circle_s2  <= circle;
			prod_s2[0] <= (2*C)'(dx) * (2*C)'(op0);
			prod_s2[1] <= (2*C)'(dy) * (2*C)'(op1);
			prod_s2[2] <= (2*C)'(dx) * (2*C)'(op2);
			prod_s2[3] <= (2*C)'(dy) * (2*C)'(op3);
			prod_s2[4] <= (2*C)'(vx) * (2*C)'(ay);
			prod_s2[5] <= (2*C)'(vy) * (2*C)'(ax);
			prod_s2[6] <= (2*C)'(vx) * (2*C)'(ax);
			prod_s2[7] <= (2*C)'(vy) * (2*C)'(ay);
			rs_sq_s2   <= (2*C+2)'(reach1) * (2*C+2)'(reach1);
			ax_s2      <= ax;
			ay_s2      <= ay;
			reach1_s2  <= reach1;
			reach2_s2  <= reach2;
			side1_s2   <= side1;
			side2_s2   <= side2;
		end
	end

	assign out_valid = valid_s2;
	assign circle_o  = circle_s2;
	assign prod      = prod_s2;
	assign rs_sq     = rs_sq_s2;
	assign ax_o      = ax_s2;
	assign ay_o      = ay_s2;
	assign reach1_o  = reach1_s2;
	assign reach2_o  = reach2_s2;
	assign side1_o   = side1_s2;
	assign side2_o   = side2_s2;

endmodule

[hdl/cbct_reduce.sv]
// ----------------------------------------------------------------------------
// cbct_reduce: third pipeline stage
// Add product pairs into projections, cross terms and the squared distance.
// ----------------------------------------------------------------------------
module cbct_reduce #(
	parameter int COMPONENT_BITS = cbct_pkg::DEF_COMPONENT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               circle,
	input  logic signed [2*COMPONENT_BITS-1:0] prod [8],
	input  logic [2*COMPONENT_BITS+1:0]        rs_sq,
	input  logic signed [COMPONENT_BITS-1:0]   ax,
	input  logic signed [COMPONENT_BITS-1:0]   ay,
	input  logic [COMPONENT_BITS:0]            reach1,
	input  logic [COMPONENT_BITS:0]            reach2,
	input  logic [COMPONENT_BITS-1:0]          side1,
	input  logic [COMPONENT_BITS-1:0]          side2,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               circle_o,
	output logic signed [2*COMPONENT_BITS:0]   d_sum,
	output logic signed [2*COMPONENT_BITS:0]   c_sum,
	output logic signed [2*COMPONENT_BITS:0]   w_sum,
	output logic signed [2*COMPONENT_BITS:0]   v_sum,
	output logic [2*COMPONENT_BITS+1:0]        rs_sq_o,
	output logic signed [COMPONENT_BITS-1:0]   ax_o,
	output logic signed [COMPONENT_BITS-1:0]   ay_o,
	output logic [COMPONENT_BITS:0]            reach1_o,
	output logic [COMPONENT_BITS:0]            reach2_o,
	output logic [COMPONENT_BITS-1:0]          side1_o,
	output logic [COMPONENT_BITS-1:0]          side2_o
);
	import cbct_pkg::*;

	localparam int C     = COMPONENT_BITS;
	localparam int SUM_W = 2 * C + 1;

	logic                    valid_s3;
	logic                    circle_s3;
	logic signed [SUM_W-1:0] d_s3, c_s3, w_s3, v_s3;
	logic [2*C+1:0]          rs_sq_s3;
	logic signed [C-1:0]     ax_s3, ay_s3;
	logic [C:0]              reach1_s3, reach2_s3;
	logic [C-1:0]            side1_s3, side2_s3;

	logic signed [SUM_W-1:0] pe [8];
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pe[i] = SUM_W'(prod[i]);
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// circle pair: d_sum is the squared distance, c_sum the approach dot
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			circle_s3 <= circle;
			d_s3      <= pe[0] + pe[1];
			c_s3      <= circle ? pe[2] + pe[3] : pe[2] - pe[3];
			w_s3      <= pe[4] - pe[5];
			v_s3      <= pe[6] + pe[7];
			rs_sq_s3  <= rs_sq;
			ax_s3     <= ax;
			ay_s3     <= ay;
			reach1_s3 <= reach1;
			reach2_s3 <= reach2;
			side1_s3  <= side1;
			side2_s3  <= side2;
		end
	end

	assign out_valid = valid_s3;
	assign circle_o  = circle_s3;
	assign d_sum     = d_s3;
	assign c_sum     = c_s3;
	assign w_sum     = w_s3;
	assign v_sum     = v_s3;
	assign rs_sq_o   = rs_sq_s3;
	assign ax_o      = ax_s3;
	assign ay_o      = ay_s3;
	assign reach1_o  = reach1_s3;
	assign reach2_o  = reach2_s3;
	assign side1_o   = side1_s3;
	assign side2_o   = side2_s3;

endmodule

[hdl/cbct_decide.sv]
// ----------------------------------------------------------------------------
// cbct_decide: fourth pipeline stage and output register
// Compare against thresholds, resolve normal flips and pick the contact normal.
// ----------------------------------------------------------------------------
module cbct_decide #(
	parameter int FRAC_BITS      = cbct_pkg::DEF_FRAC_BITS,
	parameter int COMPONENT_BITS = cbct_pkg::DEF_COMPONENT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             circle,
	input  logic signed [2*COMPONENT_BITS:0] d_sum,
	input  logic signed [2*COMPONENT_BITS:0] c_sum,
	input  logic signed [2*COMPONENT_BITS:0] w_sum,
	input  logic signed [2*COMPONENT_BITS:0] v_sum,
	input  logic [2*COMPONENT_BITS+1:0]      rs_sq,
	input  logic signed [COMPONENT_BITS-1:0] ax,
	input  logic signed [COMPONENT_BITS-1:0] ay,
	input  logic [COMPONENT_BITS:0]          reach1,
	input  logic [COMPONENT_BITS:0]          reach2,
	input  logic [COMPONENT_BITS-1:0]        side1,
	input  logic [COMPONENT_BITS-1:0]        side2,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic                             normal_valid,
	output logic [COMPONENT_BITS-1:0]        nx,
	output logic [COMPONENT_BITS-1:0]        ny
);
	import cbct_pkg::*;

	localparam int C     = COMPONENT_BITS;
	localparam int F     = FRAC_BITS;
	localparam int SUM_W = 2 * C + 1;
	localparam int CMP_W = (2 * C + 2 > C + 1 + F) ? 2 * C + 2 : C + 1 + F;

	logic         valid_s4;
	logic         hit_s4;
	logic         nvalid_s4;
	logic [C-1:0] nx_s4, ny_s4;

	logic [SUM_W-1:0] abs_d, abs_c, d_mag;
	logic [CMP_W-1:0] thr_r1, thr_r2, thr_s1, thr_s2;
	logic             d_neg, t_neg, circle_hit, test1, test2, box_hit;
	logic             hit_c, nvalid_c;
	logic [C-1:0]     nx_c, ny_c;

	assign abs_d = d_sum < 0 ? SUM_W'(-d_sum) : SUM_W'(d_sum);
	assign abs_c = c_sum < 0 ? SUM_W'(-c_sum) : SUM_W'(c_sum);
	assign d_mag = SUM_W'(d_sum);

	assign thr_r1 = CMP_W'(reach1) << F;
	assign thr_r2 = CMP_W'(reach2) << F;
	assign thr_s1 = CMP_W'(side1) << F;
	assign thr_s2 = CMP_W'(side2) << F;

	// squared distance is never negative, so its bits compare unsigned
	assign circle_hit = (CMP_W'(d_mag) <= CMP_W'(rs_sq)) && (c_sum > 0);

	// first normal flips when its projection is negative; the perpendicular's
	// sign follows the cross term, or the first flip when that term is zero
	assign d_neg = d_sum < 0;
	assign t_neg = (c_sum < 0) || ((c_sum == 0) && d_neg);

	assign test1 = (CMP_W'(abs_d) < thr_r1) && (CMP_W'(abs_c) < thr_s1)
		&& (d_neg ? (v_sum < 0) : (v_sum > 0));
	assign test2 = (CMP_W'(abs_c) < thr_r2) && (CMP_W'(abs_d) < thr_s2)
		&& (t_neg ? (w_sum < 0) : (w_sum > 0));
	assign box_hit = test1 || test2;

	always_comb begin
		hit_c    = circle ? circle_hit : box_hit;
		nvalid_c = !circle && box_hit;
		nx_c     = '0;
		ny_c     = '0;
		if (nvalid_c) begin
			if (test1) begin
				nx_c = d_neg ? C'(-ax) : C'(ax);
				ny_c = d_neg ? C'(-ay) : C'(ay);
			end else begin
				nx_c = t_neg ? C'(-ay) : C'(ay);
				ny_c = t_neg ? C'(ax) : C'(-ax);
			end
		end
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hit_s4    <= hit_c;
			nvalid_s4 <= nvalid_c;
			nx_s4     <= nx_c;
			ny_s4     <= ny_c;
		end
	end

	assign out_valid    = valid_s4;
	assign hit          = hit_s4;
	assign normal_valid = nvalid_s4;
	assign nx           = nx_s4;
	assign ny           = ny_s4;

endmodule

[hdl/circle_box_collision_test.sv]
// ----------------------------------------------------------------------------
// circle_box_collision_test: planar collision test for one pair of bodies
// Throughput: one pair per cycle while the master side takes results, through
// the four registered stages (unpack, multiplier bank, adders, compare and
// select); a stalled output holds the pipeline back.
// Reset: arst_n clears every stage valid bit at once; payload is not reset.
// Circle pairs use squared distance and approach dot; other pairs run two
// oriented-box tests on the second body's normal and its perpendicular.
// ----------------------------------------------------------------------------
module circle_box_collision_test #(
	parameter int FRAC_BITS      = cbct_pkg::DEF_FRAC_BITS,
	parameter int COMPONENT_BITS = cbct_pkg::DEF_COMPONENT_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [63:0] first_position, [127:64] second_position, [191:128] first_velocity,
	// [255:192] second_velocity, [319:256] first_extent, [383:320] second_extent,
	// [447:384] second_normal
	input  logic [447:0] s_axis_tdata,
	// [1:0] shape_pair
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] hit, [64:1] contact_normal, [71:65] zero
	output logic [71:0]  m_axis_tdata,
	// [0] contact_normal_valid
	output logic [0:0]   m_axis_tuser
);
	import cbct_pkg::*;

	localparam int C = COMPONENT_BITS;

	// Stage 1 -> 2: clamped offset, velocities, normal and extent sums
	logic                u_valid, u_ready, u_circle;
	logic signed [C-1:0] u_dx, u_dy, u_rvx, u_rvy, u_vx, u_vy, u_ax, u_ay;
	logic [C:0]          u_reach1, u_reach2;
	logic [C-1:0]        u_side1, u_side2;

	// Stage 2 -> 3: raw products
	logic                  m_valid, m_ready, m_circle;
	logic signed [2*C-1:0] m_prod [8];
	logic [2*C+1:0]        m_rs_sq;
	logic signed [C-1:0]   m_ax, m_ay;
	logic [C:0]            m_reach1, m_reach2;
	logic [C-1:0]          m_side1, m_side2;

	// Stage 3 -> 4: projections and cross terms
	logic                r_valid, r_ready, r_circle;
	logic signed [2*C:0] r_d, r_c, r_w, r_v;
	logic [2*C+1:0]      r_rs_sq;
	logic signed [C-1:0] r_ax, r_ay;
	logic [C:0]          r_reach1, r_reach2;
	logic [C-1:0]        r_side1, r_side2;

	// Result stage
	logic         d_hit, d_nvalid;
	logic [C-1:0] d_nx, d_ny;

	// Each stage takes a new transfer when it is empty or its successor takes
	// its content, so bubbles collapse while the output waits.
	cbct_unpack #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_unpack (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.shape_pair      (s_axis_tuser),
		.first_position  (s_axis_tdata[63:0]),
		.second_position (s_axis_tdata[127:64]),
		.first_velocity  (s_axis_tdata[191:128]),
		.second_velocity (s_axis_tdata[255:192]),
		.first_extent    (s_axis_tdata[319:256]),
		.second_extent   (s_axis_tdata[383:320]),
		.second_normal   (s_axis_tdata[447:384]),
		.out_valid       (u_valid),
		.out_ready       (u_ready),
		.circle          (u_circle),
		.dx              (u_dx),
		.dy              (u_dy),
		.rvx             (u_rvx),
		.rvy             (u_rvy),
		.vx              (u_vx),
		.vy              (u_vy),
		.ax              (u_ax),
		.ay              (u_ay),
		.reach1          (u_reach1),
		.reach2          (u_reach2),
		.side1           (u_side1),
		.side2           (u_side2)
	);

	cbct_mult #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (u_valid),
		.in_ready  (u_ready),
		.circle    (u_circle),
		.dx        (u_dx),
		.dy        (u_dy),
		.rvx       (u_rvx),
		.rvy       (u_rvy),
		.vx        (u_vx),
		.vy        (u_vy),
		.ax        (u_ax),
		.ay        (u_ay),
		.reach1    (u_reach1),
		.reach2    (u_reach2),
		.side1     (u_side1),
		.side2     (u_side2),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.circle_o  (m_circle),
		.prod      (m_prod),
		.rs_sq     (m_rs_sq),
		.ax_o      (m_ax),
		.ay_o      (m_ay),
		.reach1_o  (m_reach1),
		.reach2_o  (m_reach2),
		.side1_o   (m_side1),
		.side2_o   (m_side2)
	);

	cbct_reduce #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m_valid),
		.in_ready  (m_ready),
		.circle    (m_circle),
		.prod      (m_prod),
		.rs_sq     (m_rs_sq),
		.ax        (m_ax),
		.ay        (m_ay),
		.reach1    (m_reach1),
		.reach2    (m_reach2),
		.side1     (m_side1),
		.side2     (m_side2),
		.out_valid (r_valid),
		.out_ready (r_ready),
		.circle_o  (r_circle),
		.d_sum     (r_d),
		.c_sum     (r_c),
		.w_sum     (r_w),
		.v_sum     (r_v),
		.rs_sq_o   (r_rs_sq),
		.ax_o      (r_ax),
		.ay_o      (r_ay),
		.reach1_o  (r_reach1),
		.reach2_o  (r_reach2),
		.side1_o   (r_side1),
		.side2_o   (r_side2)
	);

	cbct_decide #(
		.FRAC_BITS      (FRAC_BITS),
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (r_valid),
		.in_ready     (r_ready),
		.circle       (r_circle),
		.d_sum        (r_d),
		.c_sum        (r_c),
		.w_sum        (r_w),
		.v_sum        (r_v),
		.rs_sq        (r_rs_sq),
		.ax           (r_ax),
		.ay           (r_ay),
		.reach1       (r_reach1),
		.reach2       (r_reach2),
		.side1        (r_side1),
		.side2        (r_side2),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.hit          (d_hit),
		.normal_valid (d_nvalid),
		.nx           (d_nx),
		.ny           (d_ny)
	);

	// Pack the result: normal y above x, zero above twice the component width.
	assign m_axis_tdata = {7'd0, 64'({d_ny, d_nx}), d_hit};
	assign m_axis_tuser = d_nvalid;

`ifndef SYNTHESIS
	// a valid contact normal only comes with a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[0])
		else $error("contact normal valid without hit");

	// a miss carries no normal at all
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[71:1] == '0)
		else $error("nonzero normal on a miss");

	// with the output taking every transfer the whole pipeline advances
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// an empty output stage lets every earlier stage advance
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output is empty");
`endif

endmodule

[tb/sv/circle_box_collision_test_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_box_collision_test_tb: self-checking bench for the pair collision test
// Streams directed and random body pairs into the block and predicts each
// hit, contact normal valid flag and contact normal independently. Results are
// compared in order while the sender and the receiver both stall at random.
// ----------------------------------------------------------------------------
module circle_box_collision_test_tb;

	localparam int     FB        = cbct_pkg::DEF_FRAC_BITS;
	localparam int     CB        = cbct_pkg::DEF_COMPONENT_BITS;
	localparam longint CMAX      = (longint'(1) << (CB - 1)) - 1;
	localparam int     ONE       = 1 << FB;
	localparam int     DIAG      = 46341;          // about 0.7071 in Q16.16
	localparam int     MAX_COMP  = 32'h7FFF_FFFF;
	localparam int     MIN_COMP  = 32'h8000_0000;
	localparam int     RAND_PAIRS = 800;
	localparam int     TAIL_CYCLES = 12;           // pipeline is 4 deep
	localparam int     CYCLE_LIMIT = 200000;

	// Shape selector codes: bit0 first body circle, bit1 second body circle.
	localparam logic [1:0] SHAPE_BOX_BOX       = 2'b00;
	localparam logic [1:0] SHAPE_CIRCLE_BOX    = 2'b01;
	localparam logic [1:0] SHAPE_BOX_CIRCLE    = 2'b10;
	localparam logic [1:0] SHAPE_CIRCLE_CIRCLE = cbct_pkg::SHAPE_CIRCLE_PAIR;

	typedef struct {
		bit        hit;
		bit        normal_valid;
		bit [63:0] normal;
	} contact_t;

	// Holds the in-flight contact predictions and checks each result transfer.
	class contact_scoreboard;
		contact_t    contact_q[$];
		int unsigned errors;

		function longint clamp_sym(longint v);
			if (v > CMAX) begin
				return CMAX;
			end
			if (v < -CMAX) begin
				return -CMAX;
			end
			return v;
		endfunction

		function longint comp_signed(bit [63:0] f, int k);
			bit signed [CB-1:0] raw;
			raw = f[k*CB +: CB];
			return clamp_sym(longint'(raw));
		endfunction

		function longint comp_unsigned(bit [63:0] f, int k);
			return longint'(f[k*CB +: CB]);
		endfunction

		function longint dot_prod(longint ax, longint ay, longint bx, longint by);
			return ax * bx + ay * by;
		endfunction

		// One oriented-box probe; the axis is turned to face the offset first.
		function bit box_probe(input longint dx, input longint dy,
				inout longint nx, inout longint ny, input longint vx, input longint vy,
				input longint reach, input longint side);
			longint px, py, across;
			if (dot_prod(dx, dy, nx, ny) < 0) begin
				nx = clamp_sym(-nx);
				ny = clamp_sym(-ny);
			end
			px = ny;
			py = clamp_sym(-nx);
			across = dot_prod(dx, dy, px, py);
			if (across < 0) begin
				across = -across;
			end
			return dot_prod(dx, dy, nx, ny) < (reach <<< FB)
				&& across < (side <<< FB)
				&& dot_prod(vx, vy, nx, ny) > 0;
		endfunction

		function contact_t predict_contact(bit [1:0] shapes, bit [447:0] data);
			contact_t          c;
			bit [63:0]         p1, p2, v1, v2, e1, e2, n2;
			longint            dx, dy, v1x, v1y, rvx, rvy, r1x, r1y, r2x, r2y;
			longint            ax, ay, bx, by, nx, ny;
			longint unsigned   d2, rs;
			bit                near_enough;
			{n2, e2, e1, v2, v1, p2, p1} = data;
			dx  = clamp_sym(comp_signed(p2, 0) - comp_signed(p1, 0));
			dy  = clamp_sym(comp_signed(p2, 1) - comp_signed(p1, 1));
			v1x = comp_signed(v1, 0);
			v1y = comp_signed(v1, 1);
			r1x = comp_unsigned(e1, 0);
			r1y = comp_unsigned(e1, 1);
			r2x = comp_unsigned(e2, 0);
			r2y = comp_unsigned(e2, 1);
			c.hit = 1'b0;
			c.normal_valid = 1'b0;
			c.normal = '0;
			if (shapes == SHAPE_CIRCLE_CIRCLE) begin
				rvx = clamp_sym(v1x - comp_signed(v2, 0));
				rvy = clamp_sym(v1y - comp_signed(v2, 1));
				d2 = longint'(dot_prod(dx, dy, dx, dy));
				rs = longint'(r1x) + longint'(r2x);
				// radii sum beyond the coordinate span always covers the distance
				near_enough = (rs >= (64'd1 << 32)) || (d2 <= rs * rs);
				c.hit = near_enough && dot_prod(dx, dy, rvx, rvy) > 0;
			end else begin
				ax = comp_signed(n2, 0);
				ay = comp_signed(n2, 1);
				if (box_probe(dx, dy, ax, ay, v1x, v1y, r1x + r2x, r2y)) begin
					c.hit = 1'b1;
					nx = ax;
					ny = ay;
				end else begin
					// fall back to the perpendicular of the flipped normal
					bx = ay;
					by = clamp_sym(-ax);
					if (box_probe(dx, dy, bx, by, v1x, v1y, r1y + r2y, r2x)) begin
						c.hit = 1'b1;
						nx = bx;
						ny = by;
					end
				end
				c.normal_valid = c.hit;
				if (c.hit) begin
					c.normal = {ny[CB-1:0], nx[CB-1:0]};
				end
			end
			return c;
		endfunction

		function void note_pair(bit [1:0] shapes, bit [447:0] data);
			contact_q = {contact_q, predict_contact(shapes, data)};
		endfunction

		function void check_result(bit [71:0] data, bit [0:0] user);
			contact_t c;
			if (contact_q.size() == 0) begin
				$error("result transfer with no pair pending: tdata %h tuser %h", data, user);
				errors++;
				return;
			end
			c = contact_q.pop_front();
			if (data[0] !== c.hit) begin
				$error("hit: expected %0d, got %0d", c.hit, data[0]);
				errors++;
			end
			if (user[0] !== c.normal_valid) begin
				$error("contact_normal_valid: expected %0d, got %0d", c.normal_valid, user[0]);
				errors++;
			end
			if (data[64:1] !== c.normal) begin
				$error("contact_normal: expected %h, got %h", c.normal, data[64:1]);
				errors++;
			end
			if (data[71:65] !== 7'd0) begin
				$error("tdata padding: expected %h, got %h", 7'd0, data[71:65]);
				errors++;
			end
		endfunction

		function int pending();
			return contact_q.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [447:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	contact_scoreboard sb = new();
	int unsigned       cycle_count = 0;

	circle_box_collision_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("circle_box_collision_test regression: fail");
			$finish;
		end
	end

	// Sample both sides mid-cycle, where every driven signal is settled; a
	// transfer seen here completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_pair(s_axis_tuser, s_axis_tdata);
			end
		end
	end

	// Receiver: switch at random between stall patterns.
	initial begin
		int mode, len, phase;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 120);
			for (phase = 0; phase < len; phase++) begin
				@(posedge clk);
				case (mode)
					0: begin
						m_axis_tready <= 1'b1;
					end
					1: begin
						m_axis_tready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						m_axis_tready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						m_axis_tready <= (phase % 3 == 0);
					end
				endcase
			end
		end
	end

	function automatic bit [63:0] vec2(int x, int y);
		return {y[31:0], x[31:0]};
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic bit [31:0] corner_comp();
		case ($urandom_range(0, 6))
			0: return MIN_COMP;
			1: return MAX_COMP;
			2: return 32'h8000_0001;
			3: return 32'h0;
			4: return 32'hFFFF_FFFF;
			5: return 32'(ONE);
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [63:0] corner_vec();
		return {corner_comp(), corner_comp()};
	endfunction

	function automatic bit [63:0] unit_normal();
		case ($urandom_range(0, 5))
			0: return vec2(ONE, 0);
			1: return vec2(0, ONE);
			2: return vec2(-ONE, 0);
			3: return vec2(0, -ONE);
			4: return vec2($urandom_range(0, 1) ? DIAG : -DIAG,
				$urandom_range(0, 1) ? DIAG : -DIAG);
			default: return vec2(spread(ONE), spread(ONE));
		endcase
	endfunction

	// Hold one pair on the slave side until it transfers; call at a rising edge.
	task automatic push_pair(input bit [1:0] shapes, input bit [447:0] data);
		bit took;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= shapes;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic push_bodies(input bit [1:0] shapes, input bit [63:0] p1, input bit [63:0] p2,
			input bit [63:0] v1, input bit [63:0] v2, input bit [63:0] e1,
			input bit [63:0] e2, input bit [63:0] n2);
		push_pair(shapes, {n2, e2, e1, v2, v1, p2, p1});
	endtask

	// Drop valid for a gap, with junk on the data lines meanwhile.
	task automatic idle_cycles(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {14{$urandom}};
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic run_directed();
		bit [63:0] zero_v, one_x, unit_x;
		zero_v = vec2(0, 0);
		one_x  = vec2(ONE, ONE);
		unit_x = vec2(ONE, 0);
		// circles: overlapping and approaching, separating, apart, just touching
		push_bodies(SHAPE_CIRCLE_CIRCLE, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, zero_v);
		push_bodies(SHAPE_CIRCLE_CIRCLE, zero_v, vec2(ONE + ONE / 2, 0), vec2(-ONE, 0),
			zero_v, one_x, one_x, zero_v);
		push_bodies(SHAPE_CIRCLE_CIRCLE, zero_v, vec2(5 * ONE, 0), unit_x, zero_v,
			one_x, one_x, zero_v);
		push_bodies(SHAPE_CIRCLE_CIRCLE, zero_v, vec2(2 * ONE, 0), unit_x, zero_v,
			one_x, one_x, zero_v);
		// radii sum past the coordinate span, saturating offset and velocity
		push_bodies(SHAPE_CIRCLE_CIRCLE, vec2(MIN_COMP, MIN_COMP), vec2(MAX_COMP, MAX_COMP),
			vec2(MAX_COMP, MAX_COMP), vec2(MIN_COMP, MIN_COMP), vec2(-1, 0), vec2(1, 0),
			zero_v);
		// box hit on the normal, for every non-circle shape pair
		push_bodies(SHAPE_BOX_BOX, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, unit_x);
		push_bodies(SHAPE_CIRCLE_BOX, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, unit_x);
		push_bodies(SHAPE_BOX_CIRCLE, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, unit_x);
		// normal facing away gets flipped
		push_bodies(SHAPE_BOX_BOX, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, vec2(-ONE, 0));
		// zero projection on the normal, hit through the perpendicular
		push_bodies(SHAPE_BOX_BOX, zero_v, vec2(ONE + ONE / 2, 0), unit_x, zero_v,
			one_x, one_x, vec2(0, ONE));
		// coincident centres: hit when moving along the normal, miss otherwise
		push_bodies(SHAPE_BOX_BOX, zero_v, zero_v, unit_x, zero_v, one_x, one_x, unit_x);
		push_bodies(SHAPE_BOX_BOX, zero_v, zero_v, vec2(-ONE, 0), zero_v, one_x, one_x,
			unit_x);
		// too far for either probe
		push_bodies(SHAPE_BOX_CIRCLE, zero_v, vec2(10 * ONE, 0), unit_x, zero_v,
			one_x, one_x, unit_x);
		// most negative code in the normal, large extents
		push_bodies(SHAPE_BOX_BOX, zero_v, vec2(ONE, ONE), vec2(ONE, ONE), zero_v,
			vec2(MAX_COMP, MAX_COMP), vec2(MAX_COMP, MAX_COMP), vec2(MIN_COMP, MIN_COMP));
		// all-ones, all-zero, all-maximum and mixed minimum-maximum words
		push_pair(SHAPE_BOX_BOX, {448{1'b1}});
		push_pair(SHAPE_CIRCLE_CIRCLE, {448{1'b1}});
		push_pair(SHAPE_BOX_BOX, '0);
		push_pair(SHAPE_CIRCLE_CIRCLE, '0);
		push_pair(SHAPE_BOX_CIRCLE, {7{vec2(MAX_COMP, MAX_COMP)}});
		push_pair(SHAPE_CIRCLE_BOX, {7{vec2(MIN_COMP, MAX_COMP)}});
	endtask

	// Mostly nearby bodies with unit normals, plus corner values and raw noise.
	task automatic push_random_pair();
		int        kind, span;
		bit [1:0]  shapes;
		bit [63:0] p1, p2, v1, v2, e1, e2, n2;
		kind = $urandom_range(0, 99);
		shapes = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 2))
			0: span = ONE;
			1: span = 16 * ONE;
			default: span = 1024 * ONE;
		endcase
		if (kind < 65) begin
			p1 = vec2(spread(span), spread(span));
			p2 = vec2(spread(span), spread(span));
			v1 = vec2(spread(span), spread(span));
			v2 = vec2(spread(span), spread(span));
			e1 = vec2($urandom_range(0, span), $urandom_range(0, span));
			e2 = vec2($urandom_range(0, span), $urandom_range(0, span));
			n2 = unit_normal();
			push_bodies(shapes, p1, p2, v1, v2, e1, e2, n2);
		end else if (kind < 85) begin
			push_bodies(shapes, corner_vec(), corner_vec(), corner_vec(), corner_vec(),
				corner_vec(), corner_vec(), corner_vec());
		end else begin
			push_pair(shapes, {14{$urandom}});
		end
	endtask

	initial begin
		int sent, burst;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		idle_cycles($urandom_range(1, 5));

		// bursts of back-to-back pairs separated by random gaps
		sent = 0;
		while (sent < RAND_PAIRS) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < RAND_PAIRS) begin
				push_random_pair();
				burst--;
				sent++;
			end
			idle_cycles($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
		end
		idle_cycles(1);

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("circle_box_collision_test regression: pass");
		end else begin
			$display("circle_box_collision_test regression: fail");
		end
		$finish;
	end

endmodule
